FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define LIS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// cond must never be true at a clock edge outside reset
`define LIS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error(msg);

`else

`define LIS_ASSERT(lbl, clk, rstn, prop, msg)

`define LIS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: hw/rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// LIS package
// Sizes, link and request structs, and state encodings of the LIS block.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned MAX_ITEMS = 64;  // capacity, 2..64
  localparam int unsigned IDX_W     = 6;   // element position width
  localparam int unsigned LEN_W     = 7;   // run length / predecessor width
  localparam int unsigned VAL_W     = 32;

  // predecessor code for an element that starts its run
  localparam logic [LEN_W-1:0] NO_PRED = LEN_W'(1 << IDX_W);

  // handed from each tail cell to the next one
  typedef struct packed {
    logic             less;  // this tail is strictly below the search value
    logic [LEN_W-1:0] pos;   // position of this tail's element
  } link_t;

  // per-cell result of the update step
  typedef struct packed {
    logic             hit;     // first tail not below the value
    logic             append;  // hit lands on an empty cell
    logic [LEN_W-1:0] pred;    // position of the tail one to the left
  } cell_out_t;

  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        addr;
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        pred;
  } elem_wr_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] last_idx;
    logic             ovf;
  } trace_req_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_CMP,
    CS_UPD,
    CS_START,
    CS_WAIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_WALK,
    TS_EMIT
  } trace_state_e;

endpackage

FILE: hw/rtl/lis_cell.sv
// ----------------------------------------------------------------------------
// LIS tail cell
// Holds the smallest tail of one run length and updates it from the search.
// ----------------------------------------------------------------------------
module lis_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmp_en_i,
  input  logic                             upd_en_i,
  input  logic                             clr_i,
  input  logic signed [lis_pkg::VAL_W-1:0] value_i,
  input  logic [lis_pkg::IDX_W-1:0]        pos_i,
  input  lis_pkg::link_t                   link_i,
  output lis_pkg::link_t                   link_o,
  output lis_pkg::cell_out_t               out_o
);
  import lis_pkg::*;

  logic                    valid_q;
  logic                    less_q;
  logic signed [VAL_W-1:0] tail_q;
  logic [IDX_W-1:0]        pos_q;
  logic                    hit;
  logic                    write;

  // boundary: left neighbor is below the value, this tail is not
  assign hit   = link_i.less && !less_q;
  // equal value leaves the tail alone
  assign write = upd_en_i && hit && (!valid_q || (tail_q != value_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      less_q  <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
      less_q  <= 1'b0;
    end else begin
      if (cmp_en_i) begin
        less_q <= valid_q && (tail_q < value_i);
      end
      if (write) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (write) begin
      tail_q <= value_i;
      pos_q  <= pos_i;
    end
  end

  assign link_o.less  = less_q;
  assign link_o.pos   = {1'b0, pos_q};

  assign out_o.hit    = hit;
  assign out_o.append = hit && !valid_q;
  assign out_o.pred   = hit ? link_i.pos : '0;

endmodule

FILE: hw/rtl/lis_trace.sv
// ----------------------------------------------------------------------------
// LIS traceback
// Element store, predecessor walk into a stack, and ordered result output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lis_trace (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lis_pkg::elem_wr_t                 wr_i,
  input  lis_pkg::trace_req_t               req_i,
  output logic                              done_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [lis_pkg::VAL_W-1:0]  elem_value_o,
  output logic [lis_pkg::IDX_W-1:0]         elem_position_o,
  output logic [lis_pkg::LEN_W-1:0]         lis_length_o,
  output logic                              overflow_o,
  output logic                              last_of_run_o
);
  import lis_pkg::*;

  logic signed [VAL_W-1:0] elem_val_mem [MAX_ITEMS];
  logic [LEN_W-1:0]        elem_pred_mem [MAX_ITEMS];
  logic signed [VAL_W-1:0] stack_val_mem [MAX_ITEMS];
  logic [IDX_W-1:0]        stack_pos_mem [MAX_ITEMS];

  trace_state_e            state_q, state_d;
  logic [LEN_W-1:0]        len_q;
  logic                    ovf_q;
  logic [LEN_W-1:0]        k_q;
  logic [IDX_W-1:0]        cur_q;
  logic [IDX_W-1:0]        j_q;
  logic signed [VAL_W-1:0] rd_val_q;
  logic [LEN_W-1:0]        rd_pred_q;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        push_idx;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_val_q;
  logic [IDX_W-1:0]        out_pos_q;
  logic [LEN_W-1:0]        out_len_q;
  logic                    out_ovf_q;
  logic                    out_last_q;
  logic                    walk_end;
  logic                    emit_last;
  logic                    load;

  assign rd_addr   = (state_q == TS_IDLE) ? req_i.last_idx : rd_pred_q[IDX_W-1:0];
  assign push_idx  = IDX_W'(k_q - LEN_W'(1));
  assign walk_end  = (k_q == LEN_W'(1));
  assign emit_last = ({1'b0, j_q} == LEN_W'(len_q - LEN_W'(1)));
  assign load      = (state_q == TS_EMIT) && (!out_valid_q || !out_stall_i);

  // element store: written by the update step, read along the predecessor chain
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      elem_val_mem[wr_i.addr]  <= wr_i.value;
      elem_pred_mem[wr_i.addr] <= wr_i.pred;
    end
    rd_val_q  <= elem_val_mem[rd_addr];
    rd_pred_q <= elem_pred_mem[rd_addr];
  end

  // walk runs back to front: push into the stack at the element's final slot
  always_ff @(posedge clk_i) begin
    if (state_q == TS_WALK) begin
      stack_val_mem[push_idx] <= rd_val_q;
      stack_pos_mem[push_idx] <= cur_q;
    end
    if (load) begin
      out_val_q  <= stack_val_mem[j_q];
      out_pos_q  <= stack_pos_mem[j_q];
      out_len_q  <= len_q;
      out_ovf_q  <= ovf_q;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == TS_IDLE && req_i.start) begin
      len_q <= req_i.len;
      ovf_q <= req_i.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_IDLE;
      k_q         <= '0;
      cur_q       <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        TS_IDLE: begin
          if (req_i.start) begin
            k_q   <= req_i.len;
            cur_q <= req_i.last_idx;
          end
        end
        TS_WALK: begin
          k_q   <= k_q - LEN_W'(1);
          cur_q <= rd_pred_q[IDX_W-1:0];
          j_q   <= '0;
        end
        TS_EMIT: begin
          if (load) begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        default: begin
          k_q <= '0;
        end
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      TS_IDLE: if (req_i.start) state_d = TS_WALK;
      TS_WALK: if (walk_end) state_d = TS_EMIT;
      TS_EMIT: if (load && emit_last) state_d = TS_IDLE;
      default: state_d = TS_IDLE;
    endcase
  end

  always_comb begin
    done_o = 1'b0;
    case (state_q)
      TS_EMIT: done_o = load && emit_last;
      default: done_o = 1'b0;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign elem_value_o    = out_val_q;
  assign elem_position_o = out_pos_q;
  assign lis_length_o    = out_len_q;
  assign overflow_o      = out_ovf_q;
  assign last_of_run_o   = out_last_q;

  `LIS_ASSERT_NEVER(a_walk_count, clk_i, rst_ni, (state_q == TS_WALK) && (k_q == '0), "walk with empty count")
  `LIS_ASSERT(a_emit_range, clk_i, rst_ni, (state_q == TS_EMIT) |-> ({1'b0, j_q} < len_q), "emit index past run length")
  `LIS_ASSERT_NEVER(a_start_busy, clk_i, rst_ni, req_i.start && (state_q != TS_IDLE), "traceback started while busy")

endmodule

FILE: hw/rtl/longest_increasing_subsequence_top.sv
// ----------------------------------------------------------------------------
// Longest increasing subsequence
// Patience-method LIS over a row of tail cells with traceback on the last request.
// ----------------------------------------------------------------------------
// A kept request goes through accept, a compare of the value against every
// tail cell in parallel, and an update of the one boundary cell plus the
// element store write; input stalls until the update is done. A request
// arriving with the capacity full is not kept and sets the overflow flag, and
// starts the traceback if it is the last one. After the last request the block
// walks the predecessor chain through its single-read element store at one
// element a cycle, then presents the run's results in increasing order at up
// to one per cycle while the output is not stalled; input stalls until the
// final result sits in the output register.
`include "assert_macros.svh"

module longest_increasing_subsequence_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [lis_pkg::VAL_W-1:0]  value_i,
  input  logic                              last_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [lis_pkg::VAL_W-1:0]  elem_value_o,
  output logic [lis_pkg::IDX_W-1:0]         elem_position_o,
  output logic [lis_pkg::LEN_W-1:0]         lis_length_o,
  output logic                              overflow_o,
  output logic                              last_of_run_o
);
  import lis_pkg::*;

  ctrl_state_e             state_q, state_d;
  logic signed [VAL_W-1:0] value_q;
  logic                    last_q;
  logic [LEN_W-1:0]        item_count_q;
  logic [LEN_W-1:0]        best_len_q;
  logic [IDX_W-1:0]        best_end_q;
  logic                    dropped_q;
  logic                    accept;
  logic                    full;
  logic                    cmp_en;
  logic                    upd_en;
  logic                    clr;
  logic                    trace_done;
  link_t                   link_c [MAX_ITEMS+1];
  cell_out_t               cell_out [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]    hit_vec;
  logic                    append_any;
  logic [LEN_W-1:0]        pred_any;
  elem_wr_t                elem_wr;
  trace_req_t              trace_req;

  assign accept = in_valid_i && !in_stall_o;
  assign full   = (item_count_q == LEN_W'(MAX_ITEMS));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i;
      last_q  <= last_item_i;
    end
  end

  // the left edge of the row: everything is below the value, no predecessor
  assign link_c[0].less = 1'b1;
  assign link_c[0].pos  = NO_PRED;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    lis_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmp_en_i (cmp_en),
      .upd_en_i (upd_en),
      .clr_i    (clr),
      .value_i  (value_q),
      .pos_i    (item_count_q[IDX_W-1:0]),
      .link_i   (link_c[g]),
      .link_o   (link_c[g+1]),
      .out_o    (cell_out[g])
    );
  end

  // only the boundary cell drives a nonzero result
  always_comb begin
    append_any = 1'b0;
    pred_any   = '0;
    hit_vec    = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      hit_vec[i] = cell_out[i].hit;
      append_any = append_any | cell_out[i].append;
      pred_any   = pred_any | cell_out[i].pred;
    end
  end

  assign elem_wr.en    = upd_en;
  assign elem_wr.addr  = item_count_q[IDX_W-1:0];
  assign elem_wr.value = value_q;
  assign elem_wr.pred  = pred_any;

  assign trace_req.start    = (state_q == CS_START);
  assign trace_req.len      = best_len_q;
  assign trace_req.last_idx = best_end_q;
  assign trace_req.ovf      = dropped_q;

  lis_trace u_trace (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (elem_wr),
    .req_i           (trace_req),
    .done_o          (trace_done),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .elem_value_o    (elem_value_o),
    .elem_position_o (elem_position_o),
    .lis_length_o    (lis_length_o),
    .overflow_o      (overflow_o),
    .last_of_run_o   (last_of_run_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= CS_IDLE;
      item_count_q <= '0;
      best_len_q   <= '0;
      best_end_q   <= '0;
      dropped_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        CS_IDLE: begin
          if (accept && full) begin
            dropped_q <= 1'b1;
          end
        end
        CS_UPD: begin
          item_count_q <= item_count_q + LEN_W'(1);
          if (append_any) begin
            best_len_q <= best_len_q + LEN_W'(1);
            best_end_q <= item_count_q[IDX_W-1:0];
          end
        end
        CS_START: begin
          // run handed to the traceback; start a fresh sequence
          item_count_q <= '0;
          best_len_q   <= '0;
          best_end_q   <= '0;
          dropped_q    <= 1'b0;
        end
        default: begin
          dropped_q <= dropped_q;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (accept) begin
          if (!full) begin
            state_d = CS_CMP;
          end else if (last_item_i) begin
            state_d = CS_START;
          end
        end
      end
      CS_CMP:   state_d = CS_UPD;
      CS_UPD:   state_d = last_q ? CS_START : CS_IDLE;
      CS_START: state_d = CS_WAIT;
      CS_WAIT:  if (trace_done) state_d = CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmp_en     = 1'b0;
    upd_en     = 1'b0;
    clr        = 1'b0;
    case (state_q)
      CS_IDLE:  in_stall_o = 1'b0;
      CS_CMP:   cmp_en     = 1'b1;
      CS_UPD:   upd_en     = 1'b1;
      CS_START: clr        = 1'b1;
      default:  in_stall_o = 1'b1;
    endcase
  end

  `LIS_ASSERT(a_one_boundary, clk_i, rst_ni, upd_en |-> $onehot(hit_vec), "update without exactly one boundary cell")
  `LIS_ASSERT(a_best_grows, clk_i, rst_ni, (upd_en && append_any) |=> (best_len_q == $past(best_len_q) + LEN_W'(1)), "append did not extend best length")
  `LIS_ASSERT_NEVER(a_best_bound, clk_i, rst_ni, best_len_q > item_count_q, "best length exceeds kept items")

endmodule
